### hdl/mlqs_pkg.sv
`timescale 1ns / 1ps
package mlqs_pkg;
	localparam int CLASS_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF = 8;
	localparam int BURST_BITS_DEF = 16;
	localparam logic [7:0] QUANTUM_RESET = 8'd3;

	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [1:0] CLS_RR = 2'd0;
	localparam logic [1:0] CLS_SRTF = 2'd1;
	localparam logic [1:0] CLS_SJF = 2'd2;
	localparam logic [1:0] CLS_FIFO = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_OUT
	} state_t;
endpackage

### hdl/mlqs_slot_cell.sv
`timescale 1ns / 1ps
// One slot of a min-search store. The running best (remaining, slot index)
// enters from the left neighbor and goes right one cell per cycle of scan_en.
module mlqs_slot_cell import mlqs_pkg::*; #(
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int BURST_BITS = BURST_BITS_DEF,
	parameter int IDX_BITS = 4,
	parameter logic [IDX_BITS-1:0] MY_IDX = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// write port
	input  logic                  wr_en,
	input  logic [ID_BITS-1:0]    wr_id,
	input  logic [BURST_BITS-1:0] wr_rem,
	input  logic                  dec_en,
	// scan chain
	input  logic                  scan_en,
	input  logic                  in_found,
	input  logic [BURST_BITS-1:0] in_rem,
	input  logic [IDX_BITS-1:0]   in_idx,
	output logic                  out_found,
	output logic [BURST_BITS-1:0] out_rem,
	output logic [IDX_BITS-1:0]   out_idx,
	// contents
	output logic                  valid,
	output logic [ID_BITS-1:0]    id,
	output logic [BURST_BITS-1:0] rem
);
	logic                  valid_q;
	logic [ID_BITS-1:0]    id_q;
	logic [BURST_BITS-1:0] rem_q;
	logic                  take;

	assign valid = valid_q;
	assign id = id_q;
	assign rem = rem_q;
	assign take = valid_q && (!in_found || rem_q < in_rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end else if (dec_en) begin
			valid_q <= (rem_q != {{(BURST_BITS-1){1'b0}}, 1'b1});
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q <= wr_id;
			rem_q <= wr_rem;
		end else if (dec_en) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_found <= 1'b0;
		end else if (scan_en) begin
			out_found <= in_found || valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_en) begin
			out_rem <= take ? rem_q : in_rem;
			out_idx <= take ? MY_IDX : in_idx;
		end
	end
endmodule

### hdl/mlqs_slot_store.sv
`timescale 1ns / 1ps
// Row of slot cells. A scan walks the running minimum down the row; the
// result appears at the output of the last cell.
module mlqs_slot_store import mlqs_pkg::*; #(
	parameter int DEPTH = CLASS_DEPTH_DEF,
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int BURST_BITS = BURST_BITS_DEF,
	localparam int IDX_BITS = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ins_en,
	input  logic [ID_BITS-1:0]    ins_id,
	input  logic [BURST_BITS-1:0] ins_rem,
	output logic                  full,
	input  logic                  dec_en,
	input  logic [IDX_BITS-1:0]   dec_idx,
	input  logic                  scan_en,
	output logic                  min_found,
	output logic [IDX_BITS-1:0]   min_idx,
	output logic                  sel_valid,
	output logic [ID_BITS-1:0]    sel_id,
	output logic [BURST_BITS-1:0] sel_rem
);
	logic                  f [DEPTH+1];
	logic [BURST_BITS-1:0] r [DEPTH+1];
	logic [IDX_BITS-1:0]   x [DEPTH+1];
	logic [DEPTH-1:0]      v;
	logic [ID_BITS-1:0]    ids [DEPTH];
	logic [BURST_BITS-1:0] rems [DEPTH];
	logic [DEPTH-1:0]      wr;
	logic [DEPTH-1:0]      free_below;

	assign f[0] = 1'b0;
	assign r[0] = '0;
	assign x[0] = '0;

	// lowest free slot gets the admit
	always_comb begin
		free_below[0] = 1'b0;
		for (int i = 1; i < DEPTH; i++) begin
			free_below[i] = free_below[i-1] || !v[i-1];
		end
		for (int i = 0; i < DEPTH; i++) begin
			wr[i] = ins_en && !v[i] && !free_below[i];
		end
	end
	assign full = &v;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		mlqs_slot_cell #(
			.ID_BITS(ID_BITS), .BURST_BITS(BURST_BITS),
			.IDX_BITS(IDX_BITS), .MY_IDX(IDX_BITS'(g))
		) u_cell (
			.clk, .arst_n,
			.wr_en(wr[g]), .wr_id(ins_id), .wr_rem(ins_rem),
			.dec_en(dec_en && dec_idx == IDX_BITS'(g)),
			.scan_en,
			.in_found(f[g]), .in_rem(r[g]), .in_idx(x[g]),
			.out_found(f[g+1]), .out_rem(r[g+1]), .out_idx(x[g+1]),
			.valid(v[g]), .id(ids[g]), .rem(rems[g])
		);
	end

	assign min_found = f[DEPTH];
	assign min_idx = x[DEPTH];
	assign sel_valid = v[dec_idx];
	assign sel_id = ids[dec_idx];
	assign sel_rem = rems[dec_idx];
endmodule

### hdl/mlqs_ring.sv
`timescale 1ns / 1ps
// Circular queue of (id, remaining) with head and count.
module mlqs_ring import mlqs_pkg::*; #(
	parameter int DEPTH = CLASS_DEPTH_DEF,
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int BURST_BITS = BURST_BITS_DEF,
	localparam int IDX_BITS = $clog2(DEPTH),
	localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [ID_BITS-1:0]    push_id,
	input  logic [BURST_BITS-1:0] push_rem,
	input  logic                  pop,
	input  logic                  upd,
	input  logic [BURST_BITS-1:0] upd_rem,
	output logic                  empty,
	output logic                  full,
	output logic [ID_BITS-1:0]    head_id,
	output logic [BURST_BITS-1:0] head_rem
);
	logic [ID_BITS-1:0]    id_mem [DEPTH];
	logic [BURST_BITS-1:0] rem_mem [DEPTH];
	logic [IDX_BITS-1:0]   head_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [IDX_BITS-1:0]   tail;
	logic [IDX_BITS:0]     tsum;
	logic [IDX_BITS:0]     hnext;

	// head + count is the tail both before and after a pop
	assign tsum = {1'b0, head_q} + (IDX_BITS+1)'(count_q);
	assign hnext = {1'b0, head_q} + 1'b1;
	// wrap for non power-of-two depth
	always_comb begin
		tail = (tsum >= (IDX_BITS+1)'(DEPTH)) ? IDX_BITS'(tsum - (IDX_BITS+1)'(DEPTH))
			: tsum[IDX_BITS-1:0];
	end
	assign empty = (count_q == '0);
	assign full = (count_q == CNT_BITS'(DEPTH));
	assign head_id = id_mem[head_q];
	assign head_rem = rem_mem[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= (hnext == (IDX_BITS+1)'(DEPTH)) ? '0 : hnext[IDX_BITS-1:0];
			end
			count_q <= count_q + CNT_BITS'(push) - CNT_BITS'(pop);
		end
	end

	// push after pop uses the post-pop tail: pop then push requeues at tail
	always_ff @(posedge clk) begin
		if (push) begin
			id_mem[tail] <= push_id;
			rem_mem[tail] <= push_rem;
		end
		if (upd && !pop) begin
			rem_mem[head_q] <= upd_rem;
		end
	end
endmodule

### hdl/multilevel_queue_scheduler.sv
`timescale 1ns / 1ps
// Flow: an admit goes from ST_IDLE through ST_EXEC to ST_OUT; a step first
// runs the min search down the cell row in ST_SCAN, then ST_EXEC and ST_OUT.
// One transaction at a time: in_ready is high only in ST_IDLE, and the next
// input is taken only once ST_OUT has handed off its result.
// Reset: arst_n clears all queues, slot valid bits, time and sets quantum to 3.
module multilevel_queue_scheduler import mlqs_pkg::*; #(
	parameter int CLASS_DEPTH = CLASS_DEPTH_DEF,
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int BURST_BITS = BURST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  job_id,
	input  logic [15:0] job_burst,
	input  logic [1:0]  job_class,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  ran_id,
	output logic [7:0]  ran_units,
	output logic [1:0]  ran_class,
	output logic        job_done,
	output logic        idle,
	output logic        admit_rejected,
	output logic [31:0] time_now
);
	localparam int IDX_BITS = $clog2(CLASS_DEPTH);
	localparam int CNT_BITS = $clog2(CLASS_DEPTH + 1);

	state_t state_q, state_d;
	logic [7:0]            quantum_q;
	logic [31:0]           time_q;
	logic                  cmd_q;
	logic [ID_BITS-1:0]    id_q;
	logic [BURST_BITS-1:0] burst_q;
	logic [1:0]            cls_q;
	logic [CNT_BITS-1:0]   scan_cnt_q;
	logic                  sjf_run_q;
	logic [IDX_BITS-1:0]   sjf_slot_q;
	logic [IDX_BITS-1:0]   srtf_sel_q;

	// result register
	logic                  ov_q;
	logic [7:0]            rid_q, runits_q;
	logic [1:0]            rcls_q;
	logic                  rdone_q, ridle_q, rrej_q;

	logic accept, scan_done, exec, do_admit, burst_nz;

	// stores
	logic rr_push, rr_pop, rr_upd, rr_empty, rr_full;
	logic [ID_BITS-1:0] rr_hid;
	logic [BURST_BITS-1:0] rr_hrem, rr_push_rem;
	logic ff_push, ff_pop, ff_upd, ff_empty, ff_full;
	logic [ID_BITS-1:0] ff_hid;
	logic [BURST_BITS-1:0] ff_hrem;
	logic sr_ins, sr_full, sr_dec, sr_found, sr_v;
	logic [IDX_BITS-1:0] sr_min;
	logic [ID_BITS-1:0] sr_id;
	logic [BURST_BITS-1:0] sr_rem;
	logic sj_ins, sj_full, sj_dec, sj_found, sj_v;
	logic [IDX_BITS-1:0] sj_min, sj_idx;
	logic [ID_BITS-1:0] sj_id;
	logic [BURST_BITS-1:0] sj_rem;
	logic scan_en;

	// execute-cycle decision
	logic [BURST_BITS-1:0] q_eff, rr_run;
	logic sjf_keep, sjf_go;
	logic [7:0] e_id, e_units;
	logic [1:0] e_cls;
	logic e_done, e_idle, e_rej;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = ov_q;
	assign ran_id = rid_q;
	assign ran_units = runits_q;
	assign ran_class = rcls_q;
	assign job_done = rdone_q;
	assign idle = ridle_q;
	assign admit_rejected = rrej_q;
	assign time_now = time_q;

	assign scan_done = (scan_cnt_q == CNT_BITS'(CLASS_DEPTH));
	assign scan_en = (state_q == ST_SCAN);
	assign exec = (state_q == ST_EXEC);
	assign do_admit = exec && (cmd_q == CMD_ADMIT);
	assign burst_nz = (burst_q != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = (command == CMD_STEP) ? ST_SCAN : ST_EXEC;
			ST_SCAN: if (scan_done) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_OUT;
			ST_OUT:  if (!ov_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// step decision, or the reject flag for an admit
	always_comb begin
		q_eff = (quantum_q == 8'd0) ? BURST_BITS'(1) : BURST_BITS'(quantum_q);
		if (BURST_BITS < 8 && quantum_q > 8'((1 << BURST_BITS) - 1))
			q_eff = '1;
		rr_run = (rr_hrem < q_eff) ? rr_hrem : q_eff;
		rr_push_rem = rr_hrem - rr_run;
		sjf_keep = sjf_run_q && sj_v;
		sjf_go = sjf_keep || sj_found;
		sj_idx = sjf_keep ? sjf_slot_q : sj_min;
		e_id = '0; e_units = '0; e_cls = CLS_RR;
		e_done = 1'b0; e_idle = 1'b0; e_rej = 1'b0;
		rr_pop = 1'b0; rr_upd = 1'b0; sr_dec = 1'b0; sj_dec = 1'b0;
		ff_pop = 1'b0; ff_upd = 1'b0;
		if (cmd_q == CMD_ADMIT) begin
			unique case (cls_q)
				CLS_RR:   e_rej = !burst_nz || rr_full;
				CLS_SRTF: e_rej = !burst_nz || sr_full;
				CLS_SJF:  e_rej = !burst_nz || sj_full;
				default:  e_rej = !burst_nz || ff_full;
			endcase
		end else if (!rr_empty) begin
			e_id = 8'(rr_hid); e_units = 8'(rr_run); e_cls = CLS_RR;
			e_done = (rr_push_rem == '0);
			rr_pop = 1'b1;
		end else if (sr_found) begin
			e_id = 8'(sr_id); e_units = 8'd1; e_cls = CLS_SRTF;
			e_done = (sr_rem == BURST_BITS'(1));
			sr_dec = 1'b1;
		end else if (sjf_go) begin
			e_id = 8'(sj_id); e_units = 8'd1; e_cls = CLS_SJF;
			e_done = (sj_rem == BURST_BITS'(1));
			sj_dec = 1'b1;
		end else if (!ff_empty) begin
			e_id = 8'(ff_hid); e_units = 8'd1; e_cls = CLS_FIFO;
			e_done = (ff_hrem == BURST_BITS'(1));
			ff_pop = e_done; ff_upd = !e_done;
		end else begin
			e_idle = 1'b1;
		end
	end

	// a full store drops the admit
	assign rr_push = exec && ((do_admit && cls_q == CLS_RR && burst_nz && !rr_full)
		|| (cmd_q == CMD_STEP && !rr_empty && !e_done));
	assign sr_ins = do_admit && cls_q == CLS_SRTF && burst_nz;
	assign sj_ins = do_admit && cls_q == CLS_SJF && burst_nz;
	assign ff_push = do_admit && cls_q == CLS_FIFO && burst_nz && !ff_full;

	mlqs_ring #(.DEPTH(CLASS_DEPTH), .ID_BITS(ID_BITS), .BURST_BITS(BURST_BITS)) u_rr (
		.clk, .arst_n,
		.push(rr_push),
		.push_id(cmd_q == CMD_ADMIT ? id_q : rr_hid),
		.push_rem(cmd_q == CMD_ADMIT ? burst_q : rr_push_rem),
		.pop(exec && rr_pop), .upd(exec && rr_upd), .upd_rem(rr_push_rem),
		.empty(rr_empty), .full(rr_full), .head_id(rr_hid), .head_rem(rr_hrem)
	);

	mlqs_ring #(.DEPTH(CLASS_DEPTH), .ID_BITS(ID_BITS), .BURST_BITS(BURST_BITS)) u_fifo (
		.clk, .arst_n,
		.push(ff_push), .push_id(id_q), .push_rem(burst_q),
		.pop(exec && ff_pop), .upd(exec && ff_upd), .upd_rem(ff_hrem - 1'b1),
		.empty(ff_empty), .full(ff_full), .head_id(ff_hid), .head_rem(ff_hrem)
	);

	mlqs_slot_store #(.DEPTH(CLASS_DEPTH), .ID_BITS(ID_BITS), .BURST_BITS(BURST_BITS)) u_srtf (
		.clk, .arst_n,
		.ins_en(sr_ins), .ins_id(id_q), .ins_rem(burst_q), .full(sr_full),
		.dec_en(exec && sr_dec), .dec_idx(state_q == ST_EXEC ? sr_min : srtf_sel_q),
		.scan_en, .min_found(sr_found), .min_idx(sr_min),
		.sel_valid(sr_v), .sel_id(sr_id), .sel_rem(sr_rem)
	);

	// a running SJF job stays valid until it finishes, so its slot is read directly
	mlqs_slot_store #(.DEPTH(CLASS_DEPTH), .ID_BITS(ID_BITS), .BURST_BITS(BURST_BITS)) u_sjf (
		.clk, .arst_n,
		.ins_en(sj_ins), .ins_id(id_q), .ins_rem(burst_q), .full(sj_full),
		.dec_en(exec && sj_dec), .dec_idx(sjf_run_q ? sjf_slot_q : sj_min),
		.scan_en, .min_found(sj_found), .min_idx(sj_min),
		.sel_valid(sj_v), .sel_id(sj_id), .sel_rem(sj_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quantum_q <= QUANTUM_RESET;
			time_q <= '0;
			scan_cnt_q <= '0;
			sjf_run_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) quantum_q <= cfg_wdata;
			if (accept) scan_cnt_q <= '0;
			else if (scan_en) scan_cnt_q <= scan_cnt_q + 1'b1;
			if (exec && cmd_q == CMD_STEP) begin
				time_q <= time_q + (e_idle ? 32'd1 : 32'(e_units));
				if (sjf_go && rr_empty && !sr_found) sjf_run_q <= !e_done;
			end
			if (ov_q && out_ready) ov_q <= 1'b0;
			else if (exec) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			id_q <= ID_BITS'(job_id);
			burst_q <= BURST_BITS'(job_burst);
			cls_q <= job_class;
		end
		if (exec) begin
			rid_q <= e_id; runits_q <= e_units; rcls_q <= e_cls;
			rdone_q <= e_done; ridle_q <= e_idle; rrej_q <= e_rej;
			srtf_sel_q <= sr_min;
			if (cmd_q == CMD_STEP && rr_empty && !sr_found) sjf_slot_q <= sj_idx;
		end
	end
endmodule

### tb/sv/multilevel_queue_scheduler_tb.sv
`timescale 1ns / 1ps
module multilevel_queue_scheduler_tb;
	import mlqs_pkg::*;

	localparam int DEPTH = CLASS_DEPTH_DEF;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  id;
		logic [15:0] burst;
		logic [1:0]  cls;
	} job_req_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  units;
		logic [1:0]  cls;
		logic        done;
		logic        idle;
		logic        rej;
		logic [31:0] now;
	} dispatch_t;

	typedef struct {
		logic [7:0]  id;
		logic [15:0] rem;
		bit          vld;
	} job_slot_t;

	// Directed table; expected result given where it is plain from reset state.
	typedef struct {
		job_req_t  req;
		bit        known;
		dispatch_t want;
	} table_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = CMD_ADMIT;
	logic [7:0]  job_id = '0;
	logic [15:0] job_burst = '0;
	logic [1:0]  job_class = CLS_RR;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  ran_id;
	logic [7:0]  ran_units;
	logic [1:0]  ran_class;
	logic        job_done;
	logic        idle;
	logic        admit_rejected;
	logic [31:0] time_now;

	always #5 clk = ~clk;

	multilevel_queue_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .job_id(job_id), .job_burst(job_burst), .job_class(job_class),
		.out_valid(out_valid), .out_ready(out_ready),
		.ran_id(ran_id), .ran_units(ran_units), .ran_class(ran_class),
		.job_done(job_done), .idle(idle), .admit_rejected(admit_rejected),
		.time_now(time_now)
	);

	// ---------------------------------------------------------------
	// Scheduler shadow: own copy of every class store, time, quantum
	// ---------------------------------------------------------------
	job_slot_t   rr_ring[DEPTH];
	job_slot_t   fifo_ring[DEPTH];
	int unsigned rr_head, rr_cnt, fifo_head, fifo_cnt;
	job_slot_t   srtf_slots[DEPTH];
	job_slot_t   sjf_slots[DEPTH];
	bit          sjf_busy;
	int unsigned sjf_cur;
	logic [31:0] clock_units;
	logic [7:0]  quantum;

	dispatch_t   pending_dispatch[$];
	table_row_t  typed_rows[$];
	int          errors = 0;
	bit          hold_out = 1'b0;

	function automatic int shortest(ref job_slot_t s[DEPTH]);
		int best;
		best = -1;
		for (int i = 0; i < DEPTH; i++)
			if (s[i].vld && (best < 0 || s[i].rem < s[best].rem))
				best = i;
		return best;
	endfunction

	function automatic bit slot_admit(ref job_slot_t s[DEPTH], input logic [7:0] id,
			input logic [15:0] b);
		for (int i = 0; i < DEPTH; i++)
			if (!s[i].vld) begin
				s[i].id = id;
				s[i].rem = b;
				s[i].vld = 1'b1;
				return 1'b1;
			end
		return 1'b0;
	endfunction

	task automatic shadow_reset();
		for (int i = 0; i < DEPTH; i++) begin
			srtf_slots[i].vld = 0;
			sjf_slots[i].vld = 0;
		end
		rr_head = 0; rr_cnt = 0; fifo_head = 0; fifo_cnt = 0;
		sjf_busy = 0; sjf_cur = 0;
		clock_units = '0;
		quantum = QUANTUM_RESET;
	endtask

	// Computes the result of one transaction and advances the shadow.
	function automatic dispatch_t schedule(job_req_t r);
		dispatch_t d;
		int s;
		int unsigned q, run, p;
		logic [15:0] left;
		d = '0;
		s = shortest(srtf_slots);
		if (r.cmd == CMD_ADMIT) begin
			bit ok;
			ok = 0;
			if (r.burst != 0) begin
				unique case (r.cls)
					CLS_RR: if (rr_cnt < DEPTH) begin
						p = (rr_head + rr_cnt) % DEPTH;
						rr_ring[p].id = r.id; rr_ring[p].rem = r.burst;
						rr_cnt++; ok = 1;
					end
					CLS_SRTF: ok = slot_admit(srtf_slots, r.id, r.burst);
					CLS_SJF: ok = slot_admit(sjf_slots, r.id, r.burst);
					default: if (fifo_cnt < DEPTH) begin
						p = (fifo_head + fifo_cnt) % DEPTH;
						fifo_ring[p].id = r.id; fifo_ring[p].rem = r.burst;
						fifo_cnt++; ok = 1;
					end
				endcase
			end
			d.rej = !ok;
		end else if (rr_cnt != 0) begin
			// quantum of zero behaves as one
			q = (quantum == 0) ? 1 : quantum;
			left = rr_ring[rr_head].rem;
			run = (left < q) ? left : q;
			d.id = rr_ring[rr_head].id;
			rr_head = (rr_head + 1) % DEPTH;
			rr_cnt--;
			left = 16'(left - run);
			if (left != 0) begin
				p = (rr_head + rr_cnt) % DEPTH;
				rr_ring[p].id = d.id; rr_ring[p].rem = left;
				rr_cnt++;
			end else
				d.done = 1'b1;
			d.units = 8'(run);
			d.cls = CLS_RR;
		end else if (s >= 0) begin
			d.id = srtf_slots[s].id;
			srtf_slots[s].rem--;
			if (srtf_slots[s].rem == 0) begin
				srtf_slots[s].vld = 0; d.done = 1'b1;
			end
			d.units = 8'd1; d.cls = CLS_SRTF;
		end else begin
			// SJF sticks with its chosen job until it completes
			if (!(sjf_busy && sjf_slots[sjf_cur].vld)) begin
				s = shortest(sjf_slots);
				sjf_busy = (s >= 0);
				sjf_cur = sjf_busy ? s : 0;
			end
			if (sjf_busy) begin
				d.id = sjf_slots[sjf_cur].id;
				sjf_slots[sjf_cur].rem--;
				if (sjf_slots[sjf_cur].rem == 0) begin
					sjf_slots[sjf_cur].vld = 0; sjf_busy = 0; d.done = 1'b1;
				end
				d.units = 8'd1; d.cls = CLS_SJF;
			end else if (fifo_cnt != 0) begin
				d.id = fifo_ring[fifo_head].id;
				fifo_ring[fifo_head].rem--;
				if (fifo_ring[fifo_head].rem == 0) begin
					fifo_head = (fifo_head + 1) % DEPTH;
					fifo_cnt--; d.done = 1'b1;
				end
				d.units = 8'd1; d.cls = CLS_FIFO;
			end else
				d.idle = 1'b1;
		end
		if (r.cmd == CMD_STEP)
			clock_units = clock_units + (d.idle ? 32'd1 : 32'(d.units));
		d.now = clock_units;
		return d;
	endfunction

	// ---------------------------------------------------------------
	// Result side: stall pattern plus an optional long hold-off
	// ---------------------------------------------------------------
	int unsigned stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (hold_out)
			out_ready <= 1'b0;
		else if (stall_phase[9:8] == 2'b11)
			out_ready <= 1'b1;    // stretch with no stalls
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		dispatch_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {ran_id, ran_units, ran_class, job_done, idle, admit_rejected, time_now};
			if (pending_dispatch.size() == 0) begin
				$display("%0t: result with no transaction outstanding: %p", $time, got);
				errors++;
			end else begin
				want = pending_dispatch.pop_front();
				if (got.id !== want.id) begin
					$display("%0t: ran_id exp %0d got %0d", $time, want.id, got.id); errors++;
				end
				if (got.units !== want.units) begin
					$display("%0t: ran_units exp %0d got %0d", $time, want.units, got.units);
					errors++;
				end
				if (got.cls !== want.cls) begin
					$display("%0t: ran_class exp %0d got %0d", $time, want.cls, got.cls);
					errors++;
				end
				if (got.done !== want.done) begin
					$display("%0t: job_done exp %0b got %0b", $time, want.done, got.done);
					errors++;
				end
				if (got.idle !== want.idle) begin
					$display("%0t: idle exp %0b got %0b", $time, want.idle, got.idle);
					errors++;
				end
				if (got.rej !== want.rej) begin
					$display("%0t: admit_rejected exp %0b got %0b", $time, want.rej, got.rej);
					errors++;
				end
				if (got.now !== want.now) begin
					$display("%0t: time_now exp %0d got %0d", $time, want.now, got.now);
					errors++;
				end
			end
		end
	end

	// Input side bookkeeping: predict on every accepted transaction; a directed
	// row with a typed-in value replaces the prediction.
	always @(posedge clk) begin
		dispatch_t  pred;
		table_row_t row;
		if (arst_n && in_valid && in_ready) begin
			pred = schedule({command, job_id, job_burst, job_class});
			if (typed_rows.size() != 0) begin
				row = typed_rows.pop_front();
				if (row.known)
					pred = row.want;
			end
			pending_dispatch.insert(pending_dispatch.size(), pred);
		end
	end

	// Watchdog: cycles without any accepted transaction or taken result
	int unsigned quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic send(job_req_t r);
		in_valid <= 1'b1;
		command <= r.cmd; job_id <= r.id; job_burst <= r.burst; job_class <= r.cls;
		do @(posedge clk); while (!in_ready);
	endtask

	// Bursty sender: random gap only between bursts, never between transactions within a burst
	int burst_left = 0;
	task automatic offer(job_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_dispatch.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_quantum(logic [7:0] v);
		drain();
		cfg_we <= 1'b1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		quantum = v;
	endtask

	function automatic job_req_t rand_item();
		job_req_t r;
		int k;
		r.cmd = ($urandom_range(0, 99) < 45) ? CMD_ADMIT : CMD_STEP;
		r.id = 8'($urandom);
		r.cls = 2'($urandom);
		k = $urandom_range(0, 99);
		if (k < 70) r.burst = 16'($urandom_range(1, 6));
		else if (k < 80) r.burst = 16'($urandom_range(7, 40));
		else if (k < 90) r.burst = 16'($urandom);   // long jobs, random over the full 16-bit range
		else if (k < 95) r.burst = 16'hFFFF;
		else r.burst = '0;
		return r;
	endfunction

	table_row_t rows[$];

	initial begin
		job_req_t r;
		table_row_t step_row;
		shadow_reset();
		rows = '{
			'{'{CMD_STEP, 8'd0, 16'd0, CLS_RR}, 1, '{0, 0, CLS_RR, 0, 1, 0, 32'd1}},
			'{'{CMD_ADMIT, 8'd9, 16'd0, CLS_RR}, 1, '{0, 0, CLS_RR, 0, 0, 1, 32'd1}},
			'{'{CMD_ADMIT, 8'd255, 16'hFFFF, CLS_FIFO}, 1, '{0, 0, CLS_RR, 0, 0, 0, 32'd1}},
			'{'{CMD_ADMIT, 8'd7, 16'd2, CLS_SJF}, 0, '0},
			'{'{CMD_ADMIT, 8'd8, 16'd1, CLS_SJF}, 0, '0},
			'{'{CMD_STEP, 8'd0, 16'd0, CLS_RR}, 0, '0},
			'{'{CMD_ADMIT, 8'd5, 16'd4, CLS_SRTF}, 0, '0},
			'{'{CMD_ADMIT, 8'd6, 16'd2, CLS_SRTF}, 0, '0},
			'{'{CMD_STEP, 8'd0, 16'd0, CLS_RR}, 0, '0},
			'{'{CMD_ADMIT, 8'd0, 16'd7, CLS_RR}, 0, '0},
			'{'{CMD_ADMIT, 8'd1, 16'd1, CLS_RR}, 0, '0},
			'{'{CMD_ADMIT, 8'd3, 16'd2, CLS_SJF}, 0, '0}
		};
		step_row = '{'{CMD_STEP, 8'd0, 16'd0, CLS_RR}, 0, '0};
		for (int i = 0; i < 14; i++)
			rows.insert(rows.size(), step_row);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			typed_rows.insert(typed_rows.size(), rows[i]);
			send(rows[i].req);
		end
		drain();

		// Class stores full: 17 admits into each class
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < DEPTH + 1; i++)
				send('{CMD_ADMIT, 8'(i), 16'd1, 2'(c)});
		drain();

		// Long receiver hold-off while the sender keeps offering
		hold_out = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_out = 1'b0;
			end
			for (int i = 0; i < 40; i++) send(rand_item());
		join
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_quantum(8'd1);
				1: set_quantum(8'd255);
				2: set_quantum(8'd0);
				3: set_quantum(8'($urandom_range(2, 20)));
				4: set_quantum(8'hAA);
				default: set_quantum(8'h55);
			endcase
			for (int i = 0; i < 130; i++) begin
				r = rand_item();
				offer(r);
			end
		end
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
